>>> rtl/csvtok_pkg.sv
// Shared types and constants of the CSV field tokenizer.
`timescale 1ns / 1ps

package csvtok_pkg;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	// Register indexes, word addressed (byte address 4 * index)
	localparam logic REG_DELIMITER = 1'b0;

	localparam logic [7:0] DELIMITER_RESET = CH_COMMA;

	typedef struct packed {
		logic inside_quotes;
		logic quote_pending;
		logic cr_pending;
		logic field_has_bytes;
		logic row_has_fields;
	} tok_state_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] data_byte;
		logic       field_end;
		logic       row_end;
		logic       stream_end;
	} tok_result_t;

endpackage

>>> rtl/csvtok_cfg.sv
// APB register file holding the field delimiter.
`timescale 1ns / 1ps

module csvtok_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  sep
);

	logic [7:0] delimiter_q;
	logic       sel_delim;

	assign pready    = 1'b1;
	assign sel_delim = (paddr[2] == csvtok_pkg::REG_DELIMITER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= csvtok_pkg::DELIMITER_RESET;
		end else if (psel && penable && pwrite && pready && sel_delim) begin
			delimiter_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_delim) begin
			prdata = {24'd0, delimiter_q};
		end
	end

	// zero selects comma
	assign sep = (delimiter_q == 8'd0) ? csvtok_pkg::CH_COMMA : delimiter_q;

endmodule

>>> rtl/csvtok_step.sv
// Next-state and result logic for one byte of CSV text.
`timescale 1ns / 1ps

module csvtok_step (
	input  csvtok_pkg::tok_state_t  st,
	input  logic [7:0]              c,
	input  logic                    fin,
	input  logic [7:0]              sep,
	output csvtok_pkg::tok_state_t  nxt,
	output csvtok_pkg::tok_result_t res,
	output logic                    emit
);

	logic done;
	logic outside;
	logic put;

	always_comb begin
		nxt     = st;
		res     = '0;
		done    = 1'b0;
		outside = 1'b0;
		put     = 1'b0;

		// LF right after a CR is swallowed
		if (st.cr_pending) begin
			nxt.cr_pending = 1'b0;
			if (c == csvtok_pkg::CH_LF) begin
				done = 1'b1;
			end
		end

		if (!done) begin
			if (st.quote_pending) begin
				nxt.quote_pending = 1'b0;
				if (c == csvtok_pkg::CH_QUOTE) begin
					put = 1'b1;
				end else begin
					nxt.inside_quotes = 1'b0;
					outside           = 1'b1;
				end
			end else if (st.inside_quotes) begin
				if (c == csvtok_pkg::CH_QUOTE) begin
					if (fin) begin
						nxt.inside_quotes = 1'b0;
					end else begin
						nxt.quote_pending = 1'b1;
					end
				end else begin
					put = 1'b1;
				end
			end else begin
				outside = 1'b1;
			end
		end

		// quote wins over delimiter, delimiter over line breaks
		if (outside) begin
			if (c == csvtok_pkg::CH_QUOTE) begin
				nxt.inside_quotes = 1'b1;
			end else if (c == sep) begin
				res.field_end       = 1'b1;
				nxt.field_has_bytes = 1'b0;
				nxt.row_has_fields  = 1'b1;
			end else if (c == csvtok_pkg::CH_LF || c == csvtok_pkg::CH_CR) begin
				res.field_end       = 1'b1;
				res.row_end         = 1'b1;
				nxt.field_has_bytes = 1'b0;
				nxt.row_has_fields  = 1'b0;
				nxt.cr_pending      = (c == csvtok_pkg::CH_CR);
			end else begin
				put = 1'b1;
			end
		end

		if (put) begin
			res.byte_valid      = 1'b1;
			res.data_byte       = c;
			nxt.field_has_bytes = 1'b1;
		end

		// flush any open field or row, then start over
		if (fin) begin
			if (nxt.field_has_bytes || nxt.row_has_fields) begin
				res.field_end = 1'b1;
				res.row_end   = 1'b1;
			end
			nxt = '0;
		end
		res.stream_end = fin;

		emit = res.byte_valid || res.field_end || fin;
	end

endmodule

>>> rtl/csv_field_tokenizer.sv
// Top level of the CSV field tokenizer: input register, step logic, result register.
// An accepted byte reaches the master side through the input and result registers.
// Throughput: one byte per cycle while no result waits on a full result register.
// Bytes that give no result (an LF after a CR, an opening quote) do not wait on it.
// Reset: arst_n clears all tokenizer state and valids; the delimiter returns to comma.
`timescale 1ns / 1ps

module csv_field_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // final_byte
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] data_byte, [8] field_end, [9] row_end, rest zero
	output logic        m_tuser,   // [0] byte_valid
	output logic        m_tlast,   // stream_end
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    fin_s1;
	csvtok_pkg::tok_state_t  state_q;
	csvtok_pkg::tok_state_t  state_nxt;
	csvtok_pkg::tok_result_t res;
	csvtok_pkg::tok_result_t out_q;
	logic                    out_valid_q;
	logic                    emit;
	logic                    out_free;
	logic                    adv;
	logic [7:0]              sep;

	csvtok_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sep     (sep)
	);

	csvtok_step u_step (
		.st   (state_q),
		.c    (byte_s1),
		.fin  (fin_s1),
		.sep  (sep),
		.nxt  (state_nxt),
		.res  (res),
		.emit (emit)
	);

	// a silent byte retires even while the result register is full
	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && (out_free || !emit);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			fin_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.row_end, out_q.field_end, out_q.data_byte};
	assign m_tuser  = out_q.byte_valid;
	assign m_tlast  = out_q.stream_end;

`ifndef ASSERT_OFF
	a_row_has_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> m_tdata[8])
		else $error("row_end without field_end");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
		else $error("data byte not zero without byte_valid");

	a_no_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser || m_tdata[8] || m_tlast)
		else $error("result carries nothing");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && fin_s1 |=> state_q == '0)
		else $error("state not cleared after final byte");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(state_q))
		else $error("stalled byte lost or state moved");
`endif

endmodule

>>> tb/sv/csv_field_tokenizer_test.sv
// Self-checking testbench of the CSV field tokenizer: directed table, random CSV text, APB setup.
`timescale 1ns / 1ps

module csv_field_tokenizer_test;

	localparam int          HOLD_CYCLES = 200;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          PHASE_BYTES = 210;
	localparam logic [2:0]  DELIM_ADDR  = {csvtok_pkg::REG_DELIMITER, 2'b00};

	typedef struct {
		logic [7:0]              b;
		logic                    last;
		bit                      typed;
		bit                      has;
		csvtok_pkg::tok_result_t res;
	} dir_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = 3'd0;
	logic [31:0] pwdata   = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	// tokenizer state mirror
	logic [7:0]              delim_reg;
	csvtok_pkg::tok_state_t  parse_st;
	csvtok_pkg::tok_result_t pending_tokens[$];
	dir_row_t                directed[$];

	int  errors          = 0;
	int  bytes_sent      = 0;
	int  results_checked = 0;
	int  cycles          = 0;
	int  delim_settings  = 1;
	bit  idle_on         = 1'b1;
	bit  hold_long       = 1'b0;

	csv_field_tokenizer DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic void append_byte(input logic [7:0] c,
			inout csvtok_pkg::tok_result_t res);
		res.byte_valid = 1'b1;
		res.data_byte = c;
		parse_st.field_has_bytes = 1'b1;
	endfunction

	function automatic void unquoted_byte(input logic [7:0] c,
			inout csvtok_pkg::tok_result_t res);
		logic [7:0] sep;
		sep = (delim_reg == 8'h00) ? csvtok_pkg::CH_COMMA : delim_reg;
		if (c == csvtok_pkg::CH_QUOTE) begin
			parse_st.inside_quotes = 1'b1;
		end else if (c == sep) begin
			res.field_end = 1'b1;
			parse_st.field_has_bytes = 1'b0;
			parse_st.row_has_fields = 1'b1;
		end else if (c == csvtok_pkg::CH_LF || c == csvtok_pkg::CH_CR) begin
			res.field_end = 1'b1;
			res.row_end = 1'b1;
			parse_st.field_has_bytes = 1'b0;
			parse_st.row_has_fields = 1'b0;
			if (c == csvtok_pkg::CH_CR)
				parse_st.cr_pending = 1'b1;
		end else begin
			append_byte(c, res);
		end
	endfunction

	// Advance the mirror by one byte; return 1 when the byte yields a token.
	function automatic bit tokenize_byte(input logic [7:0] c, input logic fin,
			output csvtok_pkg::tok_result_t res);
		bit absorbed;
		res = '0;
		absorbed = 1'b0;
		if (parse_st.cr_pending) begin
			parse_st.cr_pending = 1'b0;
			absorbed = (c == csvtok_pkg::CH_LF);
		end
		if (!absorbed) begin
			if (parse_st.quote_pending) begin
				parse_st.quote_pending = 1'b0;
				if (c == csvtok_pkg::CH_QUOTE) begin
					append_byte(c, res);
				end else begin
					parse_st.inside_quotes = 1'b0;
					unquoted_byte(c, res);
				end
			end else if (parse_st.inside_quotes) begin
				if (c == csvtok_pkg::CH_QUOTE) begin
					if (fin)
						parse_st.inside_quotes = 1'b0;
					else
						parse_st.quote_pending = 1'b1;
				end else begin
					append_byte(c, res);
				end
			end else begin
				unquoted_byte(c, res);
			end
		end
		// flush whatever is open at the end of the text
		if (fin) begin
			if (parse_st.field_has_bytes || parse_st.row_has_fields) begin
				res.field_end = 1'b1;
				res.row_end = 1'b1;
			end
			parse_st = '0;
		end
		res.stream_end = fin;
		return res.byte_valid || res.field_end || fin;
	endfunction

	task automatic add_row(input logic [7:0] b, input logic last, input bit typed,
			input bit has, input logic bv, input logic [7:0] d, input logic fe,
			input logic re, input logic se);
		dir_row_t r;
		r.b = b;
		r.last = last;
		r.typed = typed;
		r.has = has;
		r.res = '{bv, d, fe, re, se};
		directed.insert(directed.size(), r);
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		csvtok_pkg::tok_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_tokens.size() == 0) begin
				$error("token with no request outstanding: tdata %0h tuser %0b tlast %0b",
					m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				want = pending_tokens.pop_front();
				compare_field("byte_valid", want.byte_valid, m_tuser);
				compare_field("data_byte", want.data_byte, m_tdata[7:0]);
				compare_field("field_end", want.field_end, m_tdata[8]);
				compare_field("row_end", want.row_end, m_tdata[9]);
				compare_field("stream_end", want.stream_end, m_tlast);
				results_checked++;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_long) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_long = 1'b0;
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Call at a falling edge; returns at the falling edge after acceptance.
	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed = 1'b0,
			input bit typed_has = 1'b0, input csvtok_pkg::tok_result_t typed_res = '0);
		csvtok_pkg::tok_result_t res;
		bit has;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_tdata <= b;
		s_tlast <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		has = tokenize_byte(b, last, res);
		if (typed) begin
			has = typed_has;
			res = typed_res;
		end
		if (has)
			pending_tokens.insert(pending_tokens.size(), res);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Mostly well-formed CSV records with random content, mixed with raw noise bytes.
	task automatic send_csv(input int budget);
		int         stop_at;
		int         len;
		int         pick;
		logic [7:0] sep;
		logic [7:0] b;
		bit         quoted;
		sep = (delim_reg == 8'h00) ? csvtok_pkg::CH_COMMA : delim_reg;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 40) == 0);
			end else begin
				quoted = ($urandom_range(0, 2) == 0);
				len = $urandom_range(0, 6);
				if (quoted)
					send_byte(csvtok_pkg::CH_QUOTE, 1'b0);
				repeat (len) begin
					b = 8'($urandom_range(0, 255));
					if (quoted) begin
						case ($urandom_range(0, 7))
							0: b = sep;
							1: b = csvtok_pkg::CH_CR;
							2: b = csvtok_pkg::CH_LF;
							3: b = csvtok_pkg::CH_QUOTE;
							default: ;
						endcase
						send_byte(b, 1'b0);
						// escape a quote by doubling it
						if (b == csvtok_pkg::CH_QUOTE)
							send_byte(csvtok_pkg::CH_QUOTE, 1'b0);
					end else begin
						while (b == sep || b == csvtok_pkg::CH_QUOTE ||
								b == csvtok_pkg::CH_CR || b == csvtok_pkg::CH_LF)
							b = 8'($urandom_range(0, 255));
						send_byte(b, 1'b0);
					end
				end
				if (quoted)
					send_byte(csvtok_pkg::CH_QUOTE, $urandom_range(0, 15) == 0);
				pick = $urandom_range(0, 19);
				if (pick < 11) begin
					send_byte(sep, 1'b0);
				end else if (pick < 13) begin
					send_byte(csvtok_pkg::CH_CR, 1'b0);
				end else if (pick < 15) begin
					send_byte(csvtok_pkg::CH_LF, 1'b0);
				end else if (pick < 18) begin
					send_byte(csvtok_pkg::CH_CR, 1'b0);
					send_byte(csvtok_pkg::CH_LF, 1'b0);
				end else begin
					send_byte((pick == 18) ? sep : csvtok_pkg::CH_LF, 1'b1);
				end
			end
		end
		s_tvalid <= 1'b0;
	endtask

	// Hold until every token is out, then let bytes without a token leave the pipe.
	task automatic drain();
		while (pending_tokens.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_delimiter(input logic [7:0] value);
		logic [31:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DELIM_ADDR;
		pwdata <= {24'h0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		delim_reg = value;
		// read back
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		compare_field("delimiter", value, got[7:0]);
		delim_settings++;
	endtask

	initial begin
		logic [7:0] delims[$];
		dir_row_t   r;

		delim_reg = csvtok_pkg::DELIMITER_RESET;
		parse_st = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset delimiter is a comma
		add_row(8'h61, 1'b0, 1'b1, 1'b1, 1'b1, 8'h61, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_COMMA, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
		add_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_CR, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0);
		add_row(csvtok_pkg::CH_LF, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_QUOTE, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_COMMA, 1'b0, 1'b1, 1'b1, 1'b1, csvtok_pkg::CH_COMMA,
			1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_LF, 1'b0, 1'b1, 1'b1, 1'b1, csvtok_pkg::CH_LF,
			1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_QUOTE, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_QUOTE, 1'b0, 1'b1, 1'b1, 1'b1, csvtok_pkg::CH_QUOTE,
			1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_QUOTE, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(8'h62, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_LF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_QUOTE, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_QUOTE, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_COMMA, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_QUOTE, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(8'h78, 1'b0, 1'b1, 1'b1, 1'b1, 8'h78, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(8'h63, 1'b0, 1'b1, 1'b1, 1'b1, 8'h63, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_COMMA, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_LF, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(csvtok_pkg::CH_CR, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0);
		add_row(csvtok_pkg::CH_LF, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		foreach (directed[i]) begin
			r = directed[i];
			send_byte(r.b, r.last, r.typed, r.has, r.res);
		end
		s_tvalid <= 1'b0;
		drain();

		delims = '{8'h00, 8'hFF, 8'h3B, csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_CR,
			csvtok_pkg::CH_LF, 8'h09, 8'($urandom_range(0, 255)), csvtok_pkg::CH_COMMA};
		foreach (delims[i]) begin
			write_delimiter(delims[i]);
			if (i == 1)
				hold_long = 1'b1;
			if (i == delims.size() - 1)
				idle_on = 1'b0;
			send_csv(PHASE_BYTES);
			drain();
		end

		repeat (10) @(negedge clk);
		$display("Covered %0d bytes of CSV text under %0d delimiter settings, %0d tokens checked.",
			bytes_sent, delim_settings, results_checked);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
